### hdl/nbb_pkg.sv
// Package for the NTT butterfly with Barrett reduction: widths, register
// indexes, operation codes and the item and side-band struct types.
// No dependencies; every other file of the block uses it.
package nbb_pkg;

   localparam int MOD_BITS       = 30;
   localparam int WORD_WIDTH     = 32;
   localparam int NUM_MODULI     = 4;
   localparam int DATA_BITS      = 30;
   localparam int CSR_INDEX_BITS = 3;

   // Product b*w or x*w, Barrett product h*m, signed residue, widened sum.
   localparam int PROD_BITS = WORD_WIDTH + MOD_BITS;
   localparam int HM_BITS   = 2 * WORD_WIDTH;
   localparam int RES_BITS  = 64;
   localparam int SUM_BITS  = RES_BITS + 1;

   // Pipeline: input, prep, five Barrett stages, combine, output register.
   localparam int NUM_STAGES = 9;
   localparam int ST_INPUT   = 0;
   localparam int ST_PREP    = 1;
   localparam int BAR_STAGES = 5;
   localparam int ST_CMB     = ST_PREP + BAR_STAGES + 1;
   localparam int CMB_STAGES = 2;

   localparam logic [MOD_BITS-1:0]   MODULUS_RESET = MOD_BITS'(64'd1 << (MOD_BITS - 1));
   localparam logic [WORD_WIDTH-1:0] BARRETT_RESET = WORD_WIDTH'(64'd1 << (MOD_BITS + 1));

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS_0 = 3'd0,
      CSR_MODULUS_1 = 3'd1,
      CSR_MODULUS_2 = 3'd2,
      CSR_MODULUS_3 = 3'd3,
      CSR_BARRETT_0 = 3'd4,
      CSR_BARRETT_1 = 3'd5,
      CSR_BARRETT_2 = 3'd6,
      CSR_BARRETT_3 = 3'd7
   } nbb_csr_type;

   typedef enum logic {
      OP_FORWARD = 1'b0,
      OP_INVERSE = 1'b1
   } nbb_op_type;

   typedef struct packed {
      nbb_op_type           operation;
      logic [1:0]           bank_index;
      logic [DATA_BITS-1:0] first_in;
      logic [DATA_BITS-1:0] second_in;
      logic [DATA_BITS-1:0] twiddle;
   } nbb_req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] first_out;
      logic [DATA_BITS-1:0] second_out;
   } nbb_rsp_type;

   // Travels beside the Barrett pipeline: what the final combine needs.
   typedef struct packed {
      nbb_op_type           operation;
      logic [DATA_BITS-1:0] first_in;
      logic [MOD_BITS-1:0]  modulus;
      logic [DATA_BITS:0]   sum;
   } nbb_side_type;

endpackage

### hdl/nbb_barrett.sv
// Five-stage Barrett modular multiplier: product, quotient estimate,
// quotient times modulus, difference and correction. Uses nbb_pkg.
module nbb_barrett (
   input  logic                                 clock,
   input  logic [nbb_pkg::BAR_STAGES-1:0]       stage_en,
   input  logic [nbb_pkg::WORD_WIDTH-1:0]       operand,
   input  logic [nbb_pkg::DATA_BITS-1:0]        twiddle,
   input  logic [nbb_pkg::WORD_WIDTH-1:0]       barrett_const,
   input  nbb_pkg::nbb_side_type                side_up,
   output logic signed [nbb_pkg::RES_BITS-1:0]  residue,
   output nbb_pkg::nbb_side_type                side_down
);

   logic [nbb_pkg::PROD_BITS-1:0]  prod2_ff, prod2_in;
   logic [nbb_pkg::WORD_WIDTH-1:0] bar2_ff;
   nbb_pkg::nbb_side_type          side2_ff;

   logic [nbb_pkg::HM_BITS-1:0]    hm3_ff, hm3_in;
   logic [nbb_pkg::PROD_BITS-1:0]  prod3_ff;
   nbb_pkg::nbb_side_type          side3_ff;

   logic [nbb_pkg::PROD_BITS-1:0]  sq4_ff, sq4_in;
   logic [nbb_pkg::PROD_BITS-1:0]  prod4_ff;
   nbb_pkg::nbb_side_type          side4_ff;

   logic signed [nbb_pkg::RES_BITS-1:0] diff5_ff, diff5_in;
   nbb_pkg::nbb_side_type               side5_ff;

   logic signed [nbb_pkg::RES_BITS-1:0] res6_ff, res6_in;
   nbb_pkg::nbb_side_type               side6_ff;

   logic signed [nbb_pkg::RES_BITS-1:0] q_ext, less_one, less_two;
   logic                                diff_pos;

   assign prod2_in = nbb_pkg::PROD_BITS'(operand) * nbb_pkg::PROD_BITS'(twiddle);

   // Quotient estimate: (p >> (k-1)) times m.
   assign hm3_in = nbb_pkg::HM_BITS'(prod2_ff[nbb_pkg::MOD_BITS-1 +: nbb_pkg::WORD_WIDTH])
                 * nbb_pkg::HM_BITS'(bar2_ff);

   assign sq4_in = nbb_pkg::PROD_BITS'(hm3_ff[nbb_pkg::MOD_BITS+1 +: nbb_pkg::WORD_WIDTH])
                 * nbb_pkg::PROD_BITS'(side3_ff.modulus);

   assign diff5_in = nbb_pkg::RES_BITS'(prod4_ff) - nbb_pkg::RES_BITS'(sq4_ff);

   // A negative difference never passes either compare and takes both
   // subtractions of q.
   always_comb begin
      q_ext    = nbb_pkg::RES_BITS'(side5_ff.modulus);
      less_one = diff5_ff - q_ext;
      less_two = diff5_ff - (q_ext <<< 1);
      diff_pos = !diff5_ff[nbb_pkg::RES_BITS-1];
      if (diff_pos && less_one[nbb_pkg::RES_BITS-1]) begin
         res6_in = diff5_ff;
      end else if (diff_pos && less_two[nbb_pkg::RES_BITS-1]) begin
         res6_in = less_one;
      end else begin
         res6_in = less_two;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod2_ff <= prod2_in;
         bar2_ff  <= barrett_const;
         side2_ff <= side_up;
      end
      if (stage_en[1]) begin
         hm3_ff   <= hm3_in;
         prod3_ff <= prod2_ff;
         side3_ff <= side2_ff;
      end
      if (stage_en[2]) begin
         sq4_ff   <= sq4_in;
         prod4_ff <= prod3_ff;
         side4_ff <= side3_ff;
      end
      if (stage_en[3]) begin
         diff5_ff <= diff5_in;
         side5_ff <= side4_ff;
      end
      if (stage_en[4]) begin
         res6_ff  <= res6_in;
         side6_ff <= side5_ff;
      end
   end

   assign residue   = res6_ff;
   assign side_down = side6_ff;

endmodule

### hdl/nbb_combine.sv
// Butterfly combine: modular add and subtract of the product, halving for
// the inverse butterfly, and the result register. Uses nbb_pkg.
module nbb_combine (
   input  logic                                clock,
   input  logic [nbb_pkg::CMB_STAGES-1:0]      stage_en,
   input  logic signed [nbb_pkg::RES_BITS-1:0] residue,
   input  nbb_pkg::nbb_side_type               side_up,
   output nbb_pkg::nbb_rsp_type                rsp
);

   logic [nbb_pkg::SUM_BITS-1:0]  fsum, fdif;
   logic [nbb_pkg::DATA_BITS:0]   q_inc;
   logic [nbb_pkg::DATA_BITS-1:0] q_half;

   nbb_pkg::nbb_op_type           op7_ff;
   logic [nbb_pkg::MOD_BITS-1:0]  q7_ff;
   logic [nbb_pkg::DATA_BITS-1:0] fsum7_ff, fsum7_in;
   logic                          fsum_wrap7_ff, fsum_wrap7_in;
   logic [nbb_pkg::DATA_BITS-1:0] fdif7_ff, fdif7_in;
   logic                          fdif_wrap7_ff, fdif_wrap7_in;
   logic [nbb_pkg::DATA_BITS-1:0] half1_7_ff, half1_7_in;
   logic [nbb_pkg::DATA_BITS-1:0] half2_7_ff, half2_7_in;

   nbb_pkg::nbb_rsp_type          rsp8_ff, rsp8_in;

   always_comb begin
      fsum = nbb_pkg::SUM_BITS'(side_up.first_in) + nbb_pkg::SUM_BITS'(residue);
      fdif = nbb_pkg::SUM_BITS'(side_up.first_in) - nbb_pkg::SUM_BITS'(residue);
      // A negative sum reads as a huge unsigned value, so it wraps as well.
      fsum_wrap7_in = fsum >= nbb_pkg::SUM_BITS'(side_up.modulus);
      fdif_wrap7_in = residue[nbb_pkg::RES_BITS-1] || fdif[nbb_pkg::SUM_BITS-1];
      fsum7_in      = fsum[nbb_pkg::DATA_BITS-1:0];
      fdif7_in      = fdif[nbb_pkg::DATA_BITS-1:0];

      q_inc  = {1'b0, side_up.modulus} + (nbb_pkg::DATA_BITS+1)'(1);
      q_half = q_inc[nbb_pkg::DATA_BITS:1];
      half1_7_in = side_up.sum[nbb_pkg::DATA_BITS:1]
                 + (side_up.sum[0] ? q_half : '0);
      half2_7_in = residue[nbb_pkg::DATA_BITS:1] + (residue[0] ? q_half : '0);
   end

   always_comb begin
      if (op7_ff == nbb_pkg::OP_INVERSE) begin
         rsp8_in.first_out  = half1_7_ff;
         rsp8_in.second_out = half2_7_ff;
      end else begin
         rsp8_in.first_out  = fsum_wrap7_ff ? fsum7_ff - q7_ff : fsum7_ff;
         rsp8_in.second_out = fdif_wrap7_ff ? fdif7_ff + q7_ff : fdif7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         op7_ff        <= side_up.operation;
         q7_ff         <= side_up.modulus;
         fsum7_ff      <= fsum7_in;
         fsum_wrap7_ff <= fsum_wrap7_in;
         fdif7_ff      <= fdif7_in;
         fdif_wrap7_ff <= fdif_wrap7_in;
         half1_7_ff    <= half1_7_in;
         half2_7_ff    <= half2_7_in;
      end
      if (stage_en[1]) begin
         rsp8_ff <= rsp8_in;
      end
   end

   assign rsp = rsp8_ff;

endmodule

### hdl/ntt_butterfly_barrett.sv
// Top level of the NTT butterfly with Barrett reduction: configuration
// registers, input and prep stages, pipeline control. Uses nbb_pkg,
// nbb_barrett and nbb_combine.
//
// Channel   Ports                                 Direction  Moves
// req       req_valid, req_ready, req_data        in         one butterfly item
// rsp       rsp_valid, rsp_ready, rsp_data        out        one result item
// csr       csr_write, csr_index, csr_data        in         one register write
//
// The pipeline has nine register stages; one item can enter every cycle while the
// result is not stalled. The depth comes from the three chained Barrett multipliers
// plus the input, prep, difference, correction and combine stages.
// A stage loads when it is empty or the stage after it moves, so a stalled result
// holds the items behind it without loss and input is taken while any stage is free.
// Reset clears the valid bits and restores the moduli and Barrett constants.
module ntt_butterfly_barrett (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  nbb_pkg::nbb_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output nbb_pkg::nbb_rsp_type                rsp_data,
   input  logic                                csr_write,
   input  logic [nbb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [nbb_pkg::WORD_WIDTH-1:0]      csr_data
);

   // Configuration: one modulus and one Barrett constant for each bank.
   logic [nbb_pkg::MOD_BITS-1:0]   modulus_ff [nbb_pkg::NUM_MODULI];
   logic [nbb_pkg::MOD_BITS-1:0]   modulus_in [nbb_pkg::NUM_MODULI];
   logic [nbb_pkg::WORD_WIDTH-1:0] barrett_ff [nbb_pkg::NUM_MODULI];
   logic [nbb_pkg::WORD_WIDTH-1:0] barrett_in [nbb_pkg::NUM_MODULI];

   // Pipeline control.
   logic [nbb_pkg::NUM_STAGES-1:0] valid_ff, valid_in;
   logic [nbb_pkg::NUM_STAGES-1:0] stage_en;

   // Input stage.
   logic [1:0]                     bank_sel;
   nbb_pkg::nbb_req_type           req0_ff;
   logic [nbb_pkg::MOD_BITS-1:0]   q0_ff;
   logic [nbb_pkg::WORD_WIDTH-1:0] m0_ff;

   // Prep stage.
   logic                           a_below_b;
   logic [nbb_pkg::DATA_BITS:0]    sum_raw;
   logic [nbb_pkg::WORD_WIDTH-1:0] diff_word;
   logic [nbb_pkg::WORD_WIDTH-1:0] x1_ff, x1_in;
   logic [nbb_pkg::DATA_BITS-1:0]  w1_ff;
   logic [nbb_pkg::WORD_WIDTH-1:0] m1_ff;
   nbb_pkg::nbb_side_type          side1_ff, side1_in;

   // Between the Barrett pipeline and the combine stages.
   logic signed [nbb_pkg::RES_BITS-1:0] residue;
   nbb_pkg::nbb_side_type               side_bar;

   // Register writes must come only while the block is idle; the block itself does
   // not enforce this. No item sees a change of its bank in flight.
   always_comb begin
      for (int i = 0; i < nbb_pkg::NUM_MODULI; i++) begin
         modulus_in[i] = modulus_ff[i];
         barrett_in[i] = barrett_ff[i];
      end
      if (csr_write) begin
         unique case (csr_index)
            nbb_pkg::CSR_MODULUS_0: modulus_in[0] = csr_data[nbb_pkg::MOD_BITS-1:0];
            nbb_pkg::CSR_MODULUS_1: modulus_in[1] = csr_data[nbb_pkg::MOD_BITS-1:0];
            nbb_pkg::CSR_MODULUS_2: modulus_in[2] = csr_data[nbb_pkg::MOD_BITS-1:0];
            nbb_pkg::CSR_MODULUS_3: modulus_in[3] = csr_data[nbb_pkg::MOD_BITS-1:0];
            nbb_pkg::CSR_BARRETT_0: barrett_in[0] = csr_data;
            nbb_pkg::CSR_BARRETT_1: barrett_in[1] = csr_data;
            nbb_pkg::CSR_BARRETT_2: barrett_in[2] = csr_data;
            nbb_pkg::CSR_BARRETT_3: barrett_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < nbb_pkg::NUM_MODULI; i++) begin
            modulus_ff[i] <= nbb_pkg::MODULUS_RESET;
            barrett_ff[i] <= nbb_pkg::BARRETT_RESET;
         end
      end else begin
         for (int i = 0; i < nbb_pkg::NUM_MODULI; i++) begin
            modulus_ff[i] <= modulus_in[i];
            barrett_ff[i] <= barrett_in[i];
         end
      end
   end

   // A stage may load when it is empty or its content moves on. The last
   // stage is the result register, emptied by the consumer.
   always_comb begin
      stage_en[nbb_pkg::NUM_STAGES-1] = !valid_ff[nbb_pkg::NUM_STAGES-1] || rsp_ready;
      for (int i = nbb_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < nbb_pkg::NUM_STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[nbb_pkg::ST_INPUT];
   assign rsp_valid = valid_ff[nbb_pkg::NUM_STAGES-1];

   // A bank index beyond the configured banks falls back to bank zero.
   assign bank_sel = ({1'b0, req_data.bank_index} < 3'(nbb_pkg::NUM_MODULI))
                   ? req_data.bank_index : 2'd0;

   always_ff @(posedge clock) begin
      if (stage_en[nbb_pkg::ST_INPUT]) begin
         req0_ff <= req_data;
         q0_ff   <= modulus_ff[bank_sel];
         m0_ff   <= barrett_ff[bank_sel];
      end
   end

   // Prep: the multiplier operand is b for the forward butterfly and the
   // modular difference a-b for the inverse one, taken to the word width.
   // The modular sum a+b is needed only by the inverse butterfly.
   always_comb begin
      a_below_b = req0_ff.first_in < req0_ff.second_in;
      diff_word = nbb_pkg::WORD_WIDTH'(req0_ff.first_in)
                - nbb_pkg::WORD_WIDTH'(req0_ff.second_in)
                + (a_below_b ? nbb_pkg::WORD_WIDTH'(q0_ff) : '0);
      x1_in = (req0_ff.operation == nbb_pkg::OP_INVERSE)
            ? diff_word : nbb_pkg::WORD_WIDTH'(req0_ff.second_in);

      sum_raw = {1'b0, req0_ff.first_in} + {1'b0, req0_ff.second_in};
      side1_in.operation = req0_ff.operation;
      side1_in.first_in  = req0_ff.first_in;
      side1_in.modulus   = q0_ff;
      side1_in.sum       = (sum_raw >= {1'b0, q0_ff}) ? sum_raw - {1'b0, q0_ff} : sum_raw;
   end

   always_ff @(posedge clock) begin
      if (stage_en[nbb_pkg::ST_PREP]) begin
         x1_ff    <= x1_in;
         w1_ff    <= req0_ff.twiddle;
         m1_ff    <= m0_ff;
         side1_ff <= side1_in;
      end
   end

   nbb_barrett u_barrett (
      .clock         (clock),
      .stage_en      (stage_en[nbb_pkg::ST_PREP+1 +: nbb_pkg::BAR_STAGES]),
      .operand       (x1_ff),
      .twiddle       (w1_ff),
      .barrett_const (m1_ff),
      .side_up       (side1_ff),
      .residue       (residue),
      .side_down     (side_bar)
   );

   nbb_combine u_combine (
      .clock    (clock),
      .stage_en (stage_en[nbb_pkg::ST_CMB +: nbb_pkg::CMB_STAGES]),
      .residue  (residue),
      .side_up  (side_bar),
      .rsp      (rsp_data)
   );

endmodule

### hdl/nbb_checker.sv
// Port-level checks for the NTT butterfly with Barrett reduction, and the
// bind that attaches them to ntt_butterfly_barrett. Uses nbb_pkg.
module nbb_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input nbb_pkg::nbb_rsp_type rsp_data
);

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result item changed while stalled");

   // With the result register empty, nothing in the pipeline can block input.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with an empty result register");

   // A result taken this cycle frees every stage behind it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input blocked while the result drains");

   // Reset leaves no result behind.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

endmodule

bind ntt_butterfly_barrett nbb_checker u_nbb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
